### rtl/core/backlog_dispatch_reorder_macros.svh
// Assertion helpers for the dispatch and reorder block.
`ifndef BACKLOG_DISPATCH_REORDER_MACROS_SVH
`define BACKLOG_DISPATCH_REORDER_MACROS_SVH

// Same-cycle implication, sampled on the block clock, off during reset.
`define BDR_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BDR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/bdr_pkg.sv
package bdr_pkg;

   localparam int BACKLOG_DEPTH_DEF = 128;
   localparam int MAX_WORKERS_DEF   = 8;
   localparam int REORDER_DEPTH_DEF = 32;

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 80;

   localparam logic REQ_ARRIVAL = 1'b0;
   localparam logic REQ_DONE    = 1'b1;

   localparam logic CSR_BACKLOG_LIMIT = 1'b0;
   localparam logic CSR_WORKER_LIMIT  = 1'b1;

   typedef enum logic [1:0] {
      KIND_DISPATCH = 2'd0,
      KIND_PUBLISH  = 2'd1,
      KIND_DROP     = 2'd2,
      KIND_REJECT   = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LATCH,
      OP_FIFO_RD,
      OP_DROP,
      OP_REL_RD,
      OP_REL_STEP,
      OP_ENQ,
      OP_DISP,
      OP_REJECT,
      OP_CPL,
      OP_FLUSH
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic is_arrival;
      logic can_emit;
      logic out_free;
      logic pend_valid;
      logic win_full;
      logic bl_full;
      logic bl_nonempty;
      logic worker_free;
      logic rel_ready;
      logic rel_valid;
      logic cpl_ok;
      logic busy_ok;
      logic win_ok;
   } status_type;

endpackage

### rtl/core/bdr_ctrl.sv
module bdr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  bdr_pkg::status_type sts,
   output bdr_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_DROP, S_REL, S_REL_EMIT, S_ENQ,
      S_DISP, S_DISP_EMIT, S_FINISH
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.op   = bdr_pkg::OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = bdr_pkg::OP_LATCH;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.is_arrival) begin
               if (sts.win_full) begin
                  if (sts.can_emit) begin
                     cmd.op   = bdr_pkg::OP_REJECT;
                     state_in = S_DISP;
                  end
               end else if (sts.bl_full) begin
                  cmd.op   = bdr_pkg::OP_FIFO_RD;
                  state_in = S_DROP;
               end else begin
                  state_in = S_ENQ;
               end
            end else if (sts.cpl_ok) begin
               cmd.op   = bdr_pkg::OP_CPL;
               state_in = S_REL;
            end else begin
               state_in = S_DISP;
            end
         end
         S_DROP: begin
            if (sts.can_emit) begin
               cmd.op   = bdr_pkg::OP_DROP;
               state_in = S_REL;
            end
         end
         S_REL: begin
            if (sts.rel_ready) begin
               cmd.op   = bdr_pkg::OP_REL_RD;
               state_in = S_REL_EMIT;
            end else begin
               state_in = sts.is_arrival ? S_ENQ : S_DISP;
            end
         end
         S_REL_EMIT: begin
            // empty results retire without waiting on the output
            if (!sts.rel_valid || sts.can_emit) begin
               cmd.op   = bdr_pkg::OP_REL_STEP;
               state_in = S_REL;
            end
         end
         S_ENQ: begin
            cmd.op   = bdr_pkg::OP_ENQ;
            state_in = S_DISP;
         end
         S_DISP: begin
            if (sts.worker_free && sts.bl_nonempty) begin
               cmd.op   = bdr_pkg::OP_FIFO_RD;
               state_in = S_DISP_EMIT;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_DISP_EMIT: begin
            if (sts.can_emit) begin
               cmd.op   = bdr_pkg::OP_DISP;
               state_in = S_DISP;
            end
         end
         S_FINISH: begin
            if (!sts.pend_valid) begin
               state_in = S_IDLE;
            end else if (sts.out_free) begin
               cmd.op   = bdr_pkg::OP_FLUSH;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/bdr_datapath.sv
module bdr_datapath #(
   parameter int BACKLOG_DEPTH = bdr_pkg::BACKLOG_DEPTH_DEF,
   parameter int MAX_WORKERS   = bdr_pkg::MAX_WORKERS_DEF,
   parameter int REORDER_DEPTH = bdr_pkg::REORDER_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tuser,
   input  logic [bdr_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [1:0]                      rsp_tuser,
   output logic [bdr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tlast,
   input  logic                            csr_wr_en,
   input  logic                            csr_index,
   input  logic [7:0]                      csr_wr_data,
   input  bdr_pkg::cmd_type                cmd,
   output bdr_pkg::status_type             sts
);

   localparam int BAW = (BACKLOG_DEPTH > 1) ? $clog2(BACKLOG_DEPTH) : 1;
   localparam int BCW = $clog2(BACKLOG_DEPTH + 1);
   localparam int RAW = $clog2(REORDER_DEPTH);
   localparam int RCW = $clog2(REORDER_DEPTH + 1);
   localparam int WW  = $clog2(MAX_WORKERS + 1);

   logic [7:0]  bl_limit_ff;
   logic [3:0]  wk_limit_ff;

   logic        typ_ff;
   logic [15:0] ptag_ff;
   logic [31:0] dseq_ff;
   logic        dval_ff;
   logic [15:0] rtag_ff;

   logic [47:0]    fifo_mem [BACKLOG_DEPTH];
   logic [47:0]    fifo_rd_ff;
   logic [BAW-1:0] head_ff, tail_ff;
   logic [BCW-1:0] blcnt_ff;

   logic [REORDER_DEPTH-1:0] done_ff;
   logic [16:0]    rmem [REORDER_DEPTH];
   logic [16:0]    rmem_rd_ff;
   logic [31:0]    issue_ff, rel_ff;
   logic [RAW-1:0] rel_idx_ff;
   logic [RCW-1:0] ocnt_ff;
   logic [WW-1:0]  busy_ff;
   logic [31:0]    drop_ff;

   logic        pv_ff;
   logic [1:0]  pkind_ff;
   logic [31:0] pseq_ff, pdrop_ff;
   logic [15:0] ptagp_ff;

   logic        rv_ff, rlast_ff;
   logic [1:0]  rkind_ff;
   logic [31:0] rseq_ff, rdrop_ff;
   logic [15:0] rtago_ff;

   function automatic logic [RAW-1:0] wrap_idx(input logic [RAW-1:0] base,
                                               input logic [RAW-1:0] off);
      logic [RAW:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= (RAW+1)'(REORDER_DEPTH)) begin
         sum = sum - (RAW+1)'(REORDER_DEPTH);
      end
      return sum[RAW-1:0];
   endfunction

   function automatic logic [BAW-1:0] bump_ptr(input logic [BAW-1:0] p);
      return (p == BAW'(BACKLOG_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // effective limits
   logic [31:0] bl_eff, wk_eff;
   always_comb begin
      if (bl_limit_ff == 8'd0) begin
         bl_eff = 32'd1;
      end else if (32'(bl_limit_ff) > 32'(BACKLOG_DEPTH)) begin
         bl_eff = 32'(BACKLOG_DEPTH);
      end else begin
         bl_eff = 32'(bl_limit_ff);
      end
      if (wk_limit_ff == 4'd0) begin
         wk_eff = 32'd1;
      end else if (32'(wk_limit_ff) > 32'(MAX_WORKERS)) begin
         wk_eff = 32'(MAX_WORKERS);
      end else begin
         wk_eff = 32'(wk_limit_ff);
      end
   end

   // reorder slots follow from the offset to the release point, which stays below the depth
   logic [31:0]    off_s, off_c, disp_end;
   logic [RAW-1:0] idx_s, idx_c;
   logic           cpl_in_range;
   always_comb begin
      off_s        = fifo_rd_ff[47:16] - rel_ff;
      idx_s        = wrap_idx(rel_idx_ff, off_s[RAW-1:0]);
      off_c        = dseq_ff - rel_ff;
      idx_c        = wrap_idx(rel_idx_ff, off_c[RAW-1:0]);
      disp_end     = 32'(ocnt_ff) - 32'(blcnt_ff);
      cpl_in_range = off_c < disp_end;
   end

   logic [31:0] drop_next;
   assign drop_next = (drop_ff == '1) ? drop_ff : drop_ff + 32'd1;

   logic out_free;
   assign out_free = !rv_ff || rsp_tready;

   always_comb begin
      sts.is_arrival  = (typ_ff == bdr_pkg::REQ_ARRIVAL);
      sts.out_free    = out_free;
      sts.pend_valid  = pv_ff;
      sts.can_emit    = !pv_ff || out_free;
      sts.win_full    = (ocnt_ff == RCW'(REORDER_DEPTH));
      sts.bl_full     = (32'(blcnt_ff) >= bl_eff);
      sts.bl_nonempty = (blcnt_ff != '0);
      sts.worker_free = (32'(busy_ff) < wk_eff);
      sts.rel_ready   = (ocnt_ff != '0) && done_ff[rel_idx_ff];
      sts.rel_valid   = rmem_rd_ff[16];
      sts.cpl_ok      = cpl_in_range && !done_ff[idx_c];
      sts.busy_ok     = (32'(busy_ff) <= 32'(MAX_WORKERS));
      sts.win_ok      = (32'(ocnt_ff) <= 32'(REORDER_DEPTH));
   end

   // new result for the pending slot
   logic        emit_now;
   logic [1:0]  e_kind;
   logic [31:0] e_seq, e_drop;
   logic [15:0] e_tag;
   always_comb begin
      emit_now = 1'b0;
      e_kind   = bdr_pkg::KIND_DISPATCH;
      e_seq    = fifo_rd_ff[47:16];
      e_tag    = fifo_rd_ff[15:0];
      e_drop   = drop_ff;
      case (cmd.op)
         bdr_pkg::OP_REJECT: begin
            emit_now = 1'b1;
            e_kind   = bdr_pkg::KIND_REJECT;
            e_seq    = issue_ff;
            e_tag    = ptag_ff;
         end
         bdr_pkg::OP_DROP: begin
            emit_now = 1'b1;
            e_kind   = bdr_pkg::KIND_DROP;
            e_drop   = drop_next;
         end
         bdr_pkg::OP_REL_STEP: begin
            emit_now = rmem_rd_ff[16];
            e_kind   = bdr_pkg::KIND_PUBLISH;
            e_seq    = rel_ff;
            e_tag    = rmem_rd_ff[15:0];
         end
         bdr_pkg::OP_DISP: begin
            emit_now = 1'b1;
         end
         default: emit_now = 1'b0;
      endcase
   end

   // pending slot and output register; pending goes out once the next result or the end is known
   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else begin
         if ((emit_now && pv_ff) || cmd.op == bdr_pkg::OP_FLUSH) begin
            rv_ff <= 1'b1;
         end else if (rsp_tready) begin
            rv_ff <= 1'b0;
         end
         if (emit_now) begin
            pv_ff <= 1'b1;
         end else if (cmd.op == bdr_pkg::OP_FLUSH) begin
            pv_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((emit_now && pv_ff) || cmd.op == bdr_pkg::OP_FLUSH) begin
         rkind_ff <= pkind_ff;
         rseq_ff  <= pseq_ff;
         rtago_ff <= ptagp_ff;
         rdrop_ff <= pdrop_ff;
         rlast_ff <= (cmd.op == bdr_pkg::OP_FLUSH);
      end
      if (emit_now) begin
         pkind_ff <= e_kind;
         pseq_ff  <= e_seq;
         ptagp_ff <= e_tag;
         pdrop_ff <= e_drop;
      end
      if (cmd.op == bdr_pkg::OP_LATCH) begin
         typ_ff  <= req_tuser;
         ptag_ff <= req_tdata[15:0];
         dseq_ff <= req_tdata[47:16];
         dval_ff <= req_tdata[48];
         rtag_ff <= req_tdata[64:49];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         bl_limit_ff <= 8'd128;
         wk_limit_ff <= 4'd4;
         head_ff     <= '0;
         tail_ff     <= '0;
         blcnt_ff    <= '0;
         done_ff     <= '0;
         issue_ff    <= '0;
         rel_ff      <= '0;
         rel_idx_ff  <= '0;
         ocnt_ff     <= '0;
         busy_ff     <= '0;
         drop_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == bdr_pkg::CSR_BACKLOG_LIMIT) begin
               bl_limit_ff <= csr_wr_data;
            end else begin
               wk_limit_ff <= csr_wr_data[3:0];
            end
         end
         case (cmd.op)
            bdr_pkg::OP_DROP: begin
               head_ff        <= bump_ptr(head_ff);
               blcnt_ff       <= blcnt_ff - 1'b1;
               drop_ff        <= drop_next;
               done_ff[idx_s] <= 1'b1;
            end
            bdr_pkg::OP_CPL: begin
               done_ff[idx_c] <= 1'b1;
               if (busy_ff != '0) begin
                  busy_ff <= busy_ff - 1'b1;
               end
            end
            bdr_pkg::OP_REL_STEP: begin
               done_ff[rel_idx_ff] <= 1'b0;
               rel_ff              <= rel_ff + 32'd1;
               rel_idx_ff          <= wrap_idx(rel_idx_ff, RAW'(1));
               ocnt_ff             <= ocnt_ff - 1'b1;
            end
            bdr_pkg::OP_ENQ: begin
               tail_ff  <= bump_ptr(tail_ff);
               blcnt_ff <= blcnt_ff + 1'b1;
               issue_ff <= issue_ff + 32'd1;
               ocnt_ff  <= ocnt_ff + 1'b1;
            end
            bdr_pkg::OP_DISP: begin
               head_ff  <= bump_ptr(head_ff);
               blcnt_ff <= blcnt_ff - 1'b1;
               busy_ff  <= busy_ff + 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // backlog memory
   always_ff @(posedge clock) begin
      if (cmd.op == bdr_pkg::OP_ENQ) begin
         fifo_mem[tail_ff] <= {issue_ff, ptag_ff};
      end
      if (cmd.op == bdr_pkg::OP_FIFO_RD) begin
         fifo_rd_ff <= fifo_mem[head_ff];
      end
   end

   // reorder result memory: valid flag and result handle
   always_ff @(posedge clock) begin
      if (cmd.op == bdr_pkg::OP_CPL) begin
         rmem[idx_c] <= {dval_ff, rtag_ff};
      end else if (cmd.op == bdr_pkg::OP_DROP) begin
         rmem[idx_s] <= 17'd0;
      end
      if (cmd.op == bdr_pkg::OP_REL_RD) begin
         rmem_rd_ff <= rmem[rel_idx_ff];
      end
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tuser  = rkind_ff;
   assign rsp_tdata  = {rdrop_ff, rtago_ff, rseq_ff};
   assign rsp_tlast  = rlast_ff;

endmodule

### rtl/core/backlog_dispatch_reorder.sv
// Each transfer is latched and decoded; a reject or an ignored completion then goes
// straight to dispatch, while an enqueue, an accepted completion, a drop, each
// release step and each dispatch add states before the last result is registered.
// One event at a time: the next transfer is taken once the sequencer is idle again,
// and a stalled result holds the sequencer. Reset (synchronous, active high) empties
// the backlog, clears all reorder done bits and counters, and restores both limits.
`include "backlog_dispatch_reorder_macros.svh"

module backlog_dispatch_reorder #(
   parameter int BACKLOG_DEPTH = bdr_pkg::BACKLOG_DEPTH_DEF,
   parameter int MAX_WORKERS   = bdr_pkg::MAX_WORKERS_DEF,
   parameter int REORDER_DEPTH = bdr_pkg::REORDER_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // req_type
   input  logic                           req_tuser,
   // payload_tag, done_seq, done_valid, result_tag, zero fill
   input  logic [bdr_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // out_kind
   output logic [1:0]                     rsp_tuser,
   // out_seq, out_tag, dropped_total
   output logic [bdr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast,
   input  logic                           csr_wr_en,
   input  logic                           csr_index,
   input  logic [7:0]                     csr_wr_data
);

   bdr_pkg::cmd_type    cmd;
   bdr_pkg::status_type sts;

   bdr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bdr_datapath #(
      .BACKLOG_DEPTH (BACKLOG_DEPTH),
      .MAX_WORKERS   (MAX_WORKERS),
      .REORDER_DEPTH (REORDER_DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts)
   );

   `BDR_ASSERT_NEXT(a_accept_holds_off, req_tvalid && req_tready, !req_tready, "accepted twice")
   `BDR_ASSERT_IMPL(a_idle_drained, req_tready, !sts.pend_valid, "pending result left at idle")
   `BDR_ASSERT_IMPL(a_bounds, 1'b1, sts.busy_ok && sts.win_ok, "worker or window count overrun")

endmodule

### verif/backlog_dispatch_reorder_tb.sv
module backlog_dispatch_reorder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 5000;
   localparam int WINDOW = bdr_pkg::REORDER_DEPTH_DEF;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic req_tuser;
   logic [bdr_pkg::REQ_DATA_W-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [1:0] rsp_tuser;
   logic [bdr_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_wr_en;
   logic csr_index;
   logic [7:0] csr_wr_data;

   backlog_dispatch_reorder DUT (.*);

   typedef struct {
      bdr_pkg::kind_type kind;
      logic [31:0]       seq;
      logic [15:0]       tag;
      logic [31:0]       dropped;
      logic              last;
   } event_rsp_type;

   typedef struct {
      logic [31:0] seq;
      logic [15:0] tag;
   } queued_msg_type;

   typedef struct {
      logic              is_done;
      logic [15:0]       payload;
      logic [31:0]       seq;
      logic              ok;
      logic [15:0]       result;
      bit                typed;
      bdr_pkg::kind_type want_kind;
      logic [31:0]       want_seq;
   } stim_row_type;

   // predictor state
   event_rsp_type  pending_rsp[$];
   queued_msg_type backlog_q[$];
   logic [31:0] in_flight[$];
   logic        slot_done[WINDOW];
   logic        slot_valid[WINDOW];
   logic [15:0] slot_tag[WINDOW];
   logic [31:0] issue_seq, release_seq, drop_total;
   logic [3:0]  busy_cnt;
   logic [7:0]  backlog_lim;
   logic [3:0]  worker_lim;

   int errors = 0;
   int idle_mode = 0;
   int quiet_cycles = 0;

   stim_row_type directed[] = '{
      '{bdr_pkg::REQ_ARRIVAL, 16'h0000, 32'h0, 1'b0, 16'h0, 1'b1, bdr_pkg::KIND_DISPATCH, 32'd0},
      '{bdr_pkg::REQ_ARRIVAL, 16'hFFFF, 32'hFFFFFFFF, 1'b1, 16'hFFFF, 1'b0,
        bdr_pkg::KIND_DISPATCH, 32'd0},
      '{bdr_pkg::REQ_ARRIVAL, 16'h1234, 32'h0, 1'b0, 16'h0, 1'b1, bdr_pkg::KIND_DROP, 32'd1},
      '{bdr_pkg::REQ_DONE, 16'h0, 32'd2, 1'b1, 16'h0F0F, 1'b0, bdr_pkg::KIND_DISPATCH, 32'd0},
      '{bdr_pkg::REQ_DONE, 16'hFFFF, 32'd0, 1'b1, 16'hFFFF, 1'b1, bdr_pkg::KIND_PUBLISH, 32'd0},
      '{bdr_pkg::REQ_DONE, 16'h0, 32'd0, 1'b1, 16'h1111, 1'b0, bdr_pkg::KIND_DISPATCH, 32'd0},
      '{bdr_pkg::REQ_DONE, 16'h0, 32'hFFFFFFFF, 1'b1, 16'h2222, 1'b0,
        bdr_pkg::KIND_DISPATCH, 32'd0},
      '{bdr_pkg::REQ_DONE, 16'h0, 32'd2, 1'b0, 16'hFFFF, 1'b0, bdr_pkg::KIND_DISPATCH, 32'd0},
      '{bdr_pkg::REQ_ARRIVAL, 16'hAAAA, 32'h0, 1'b0, 16'h0, 1'b1, bdr_pkg::KIND_DISPATCH, 32'd3},
      '{bdr_pkg::REQ_DONE, 16'h0, 32'd3, 1'b1, 16'h5555, 1'b1, bdr_pkg::KIND_PUBLISH, 32'd3},
      '{bdr_pkg::REQ_ARRIVAL, 16'h5555, 32'h0, 1'b0, 16'h0, 1'b0, bdr_pkg::KIND_DISPATCH, 32'd0},
      '{bdr_pkg::REQ_ARRIVAL, 16'hA5A5, 32'h0, 1'b0, 16'h0, 1'b0, bdr_pkg::KIND_DISPATCH, 32'd0}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void emit_rsp(bdr_pkg::kind_type kind, logic [31:0] seq,
                                    logic [15:0] tag);
      event_rsp_type r;
      r.kind = kind;
      r.seq = seq;
      r.tag = tag;
      r.dropped = drop_total;
      r.last = 1'b0;
      pending_rsp.push_back(r);
   endfunction

   function automatic void release_walk();
      int idx;
      while (release_seq != issue_seq) begin
         idx = release_seq % WINDOW;
         if (!slot_done[idx]) break;
         if (slot_valid[idx]) emit_rsp(bdr_pkg::KIND_PUBLISH, release_seq, slot_tag[idx]);
         slot_done[idx] = 1'b0;
         slot_valid[idx] = 1'b0;
         release_seq++;
      end
   endfunction

   function automatic void predict_event(logic is_done, logic [15:0] payload,
                                          logic [31:0] seq, logic ok, logic [15:0] result);
      int base;
      int blim;
      int wlim;
      int idx;
      queued_msg_type m;
      logic [31:0] off, disp_end;
      base = pending_rsp.size();
      blim = (backlog_lim == 0) ? 1 : (backlog_lim > bdr_pkg::BACKLOG_DEPTH_DEF) ?
             bdr_pkg::BACKLOG_DEPTH_DEF : int'(backlog_lim);
      wlim = (worker_lim == 0) ? 1 : (worker_lim > bdr_pkg::MAX_WORKERS_DEF) ?
             bdr_pkg::MAX_WORKERS_DEF : int'(worker_lim);
      if (is_done == bdr_pkg::REQ_ARRIVAL) begin
         if (issue_seq - release_seq >= WINDOW) begin
            emit_rsp(bdr_pkg::KIND_REJECT, issue_seq, payload);
         end else begin
            if (backlog_q.size() >= blim) begin
               m = backlog_q.pop_front();
               if (drop_total != 32'hFFFFFFFF) drop_total++;
               emit_rsp(bdr_pkg::KIND_DROP, m.seq, m.tag);
               slot_done[m.seq % WINDOW] = 1'b1;
               slot_valid[m.seq % WINDOW] = 1'b0;
               release_walk();
            end
            m.seq = issue_seq;
            m.tag = payload;
            backlog_q.push_back(m);
            issue_seq++;
         end
      end else begin
         off = seq - release_seq;
         disp_end = (issue_seq - backlog_q.size()) - release_seq;
         idx = seq % WINDOW;
         if (off < disp_end && !slot_done[idx]) begin
            if (busy_cnt > 0) busy_cnt--;
            slot_done[idx] = 1'b1;
            slot_valid[idx] = ok;
            slot_tag[idx] = result;
            foreach (in_flight[i]) if (in_flight[i] == seq) begin
               in_flight.delete(i);
               break;
            end
            release_walk();
         end
      end
      while (busy_cnt < wlim && backlog_q.size() > 0) begin
         m = backlog_q.pop_front();
         busy_cnt++;
         in_flight.push_back(m.seq);
         emit_rsp(bdr_pkg::KIND_DISPATCH, m.seq, m.tag);
      end
      if (pending_rsp.size() > base) pending_rsp[pending_rsp.size() - 1].last = 1'b1;
   endfunction

   // returns the index of the first result this transfer produced
   task automatic send_event(logic is_done, logic [15:0] payload, logic [31:0] seq,
                             logic ok, logic [15:0] result, output int first);
      int p;
      p = (idle_mode == 1) ? 63 : (idle_mode == 3) ? 36 : 0;
      if (p > 0 && $urandom_range(99) < p) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= is_done;
      req_tdata <= {7'd0, result, ok, seq, payload};
      do @(posedge clock); while (!req_tready);
      first = pending_rsp.size();
      predict_event(is_done, payload, seq, ok, result);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_limits(logic [7:0] blim, logic [7:0] wlim);
      csr_wr_en <= 1'b1;
      csr_index <= bdr_pkg::CSR_BACKLOG_LIMIT;
      csr_wr_data <= blim;
      @(posedge clock);
      csr_index <= bdr_pkg::CSR_WORKER_LIMIT;
      csr_wr_data <= wlim;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      backlog_lim = blim;
      worker_lim = wlim[3:0];
   endtask

   // check each result transfer against the oldest expectation
   always @(posedge clock) begin
      event_rsp_type e;
      int p;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected result kind=%0d seq=%0d", rsp_tuser, rsp_tdata[31:0]);
            errors++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_tuser !== e.kind) begin
               $error("out_kind exp %0d got %0d", e.kind, rsp_tuser);
               errors++;
            end
            if (rsp_tdata[31:0] !== e.seq) begin
               $error("out_seq exp %0d got %0d", e.seq, rsp_tdata[31:0]);
               errors++;
            end
            if (rsp_tdata[47:32] !== e.tag) begin
               $error("out_tag exp %h got %h", e.tag, rsp_tdata[47:32]);
               errors++;
            end
            if (rsp_tdata[79:48] !== e.dropped) begin
               $error("dropped_total exp %0d got %0d", e.dropped, rsp_tdata[79:48]);
               errors++;
            end
            if (rsp_tlast !== e.last) begin
               $error("last exp %0d got %0d", e.last, rsp_tlast);
               errors++;
            end
         end
      end
      p = (idle_mode == 2) ? 63 : (idle_mode == 3) ? 36 : 0;
      rsp_tready <= ($urandom_range(99) >= p);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("backlog_dispatch_reorder_tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int first;
      int pick;
      int arrive_pct;
      logic [7:0] phase_blim[8] = '{8'd128, 8'd255, 8'd1, 8'd0, 8'd3, 8'd6, 8'd128, 8'd2};
      logic [7:0] phase_wlim[8] = '{8'h04, 8'hFF, 8'h01, 8'hF0, 8'h02, 8'h08, 8'h01, 8'h03};
      int phase_pct[8] = '{55, 55, 75, 60, 65, 55, 90, 60};
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = bdr_pkg::REQ_ARRIVAL;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = bdr_pkg::CSR_BACKLOG_LIMIT;
      csr_wr_data = '0;
      issue_seq = '0;
      release_seq = '0;
      drop_total = '0;
      busy_cnt = '0;
      backlog_lim = 8'd128;
      worker_lim = 4'd4;
      foreach (slot_done[i]) begin
         slot_done[i] = 1'b0;
         slot_valid[i] = 1'b0;
         slot_tag[i] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_limits(8'd1, 8'd1);
      foreach (directed[r]) begin
         send_event(directed[r].is_done, directed[r].payload, directed[r].seq,
                    directed[r].ok, directed[r].result, first);
         if (directed[r].typed) begin
            if (pending_rsp.size() <= first) begin
               $error("row %0d: no result, expected kind %0d", r, directed[r].want_kind);
               errors++;
            end else if (pending_rsp[first].kind != directed[r].want_kind ||
                         pending_rsp[first].seq != directed[r].want_seq) begin
               $error("row %0d: kind/seq exp %0d/%0d got %0d/%0d", r,
                      directed[r].want_kind, directed[r].want_seq,
                      pending_rsp[first].kind, pending_rsp[first].seq);
               errors++;
            end
         end
      end

      for (int ph = 0; ph < 8; ph++) begin
         drain();
         write_limits(phase_blim[ph], phase_wlim[ph]);
         idle_mode = ph % 4;
         arrive_pct = phase_pct[ph];
         for (int n = 0; n < 62; n++) begin
            // hold off once until every expected result has come out
            if (ph == 4 && n == 30) begin
               req_tvalid <= 1'b0;
               while (pending_rsp.size() != 0) @(posedge clock);
            end
            if ($urandom_range(99) < arrive_pct || in_flight.size() == 0) begin
               if ($urandom_range(9) == 0)
                  send_event(bdr_pkg::REQ_DONE, 16'($urandom), $urandom, 1'($urandom),
                             16'($urandom), first);
               else
                  send_event(bdr_pkg::REQ_ARRIVAL, 16'($urandom), $urandom, 1'($urandom),
                             16'($urandom), first);
            end else begin
               pick = $urandom_range(in_flight.size() - 1);
               send_event(bdr_pkg::REQ_DONE, 16'($urandom), in_flight[pick],
                          ($urandom_range(3) != 0), 16'($urandom), first);
            end
         end
      end

      // complete everything left so the release path drains
      idle_mode = 0;
      while (in_flight.size() != 0)
         send_event(bdr_pkg::REQ_DONE, 16'($urandom), in_flight[0], 1'b1, 16'($urandom),
                    first);
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (pending_rsp.size() != 0) errors++;
      if (errors == 0) begin
         $display("backlog_dispatch_reorder_tb: clean");
      end else begin
         $display("backlog_dispatch_reorder_tb: errors");
      end
      $finish;
   end
endmodule
